@@ design/nfba_pkg.sv @@
// Shared types and constants of the next-fit block allocator.
package nfba_pkg;

  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = 5;
  localparam int CNT_BITS   = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_BLOCK_COUNT   = 1'b0;
  localparam logic [CNT_BITS-1:0]   BLOCK_COUNT_RESET = 6'd32;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [IDX_BITS-1:0]  block_index;
    logic [SIZE_BITS-1:0] size_kb;
  } in_beat_t;

  typedef struct packed {
    logic                 allocated;
    logic [IDX_BITS-1:0]  chosen_block;
    logic [SIZE_BITS-1:0] size_before;
    logic [SIZE_BITS-1:0] fragment_kb;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

@@ design/next_fit_block_allocator_top.sv @@
// Top level of the next-fit block allocator: sequencer, free-size table and result register.
// After reset the free-size table is zeroed by a clearing pass over all MAX_BLOCKS entries,
// during which in_stall is high; configuration writes are taken throughout. A load beat
// writes the table as the beat is accepted; its result is registered and passes to the
// output register once the output is free. An allocate beat scans the table one block per
// cycle through a single compare and subtract unit behind the registered read port of the
// table, reading at most n blocks, where n is the smaller of block_count and MAX_BLOCKS.
// With a block count of zero a request is refused without a scan and finishes as a load
// does. The result register lets a new beat be accepted and worked on while the previous
// result still waits on out_stall.
module next_fit_block_allocator_top
  import nfba_pkg::*;
#(
  parameter int MAX_BLOCKS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NB_W = $clog2(MAX_BLOCKS + 1);
  localparam int CW   = (NB_W > CNT_BITS) ? NB_W : CNT_BITS;

  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  block_count_r;
  logic [IW-1:0]        ptr_r;
  logic [IW-1:0]        clr_idx_r;
  logic [IW-1:0]        rd_idx_r;
  logic [NB_W-1:0]      iss_cnt_r;
  logic                 cmp_v_r;
  logic                 cmp_last_r;
  logic [IW-1:0]        cmp_idx_r;
  logic [SIZE_BITS-1:0] rdata_r;
  logic [SIZE_BITS-1:0] req_r;
  out_beat_t            res_r;
  out_beat_t            out_r;
  logic                 out_valid_r;

  logic [SIZE_BITS-1:0] table_mem [MAX_BLOCKS];

  logic [NB_W-1:0]      n_act;
  logic [IW-1:0]        start_idx;
  logic                 in_acc;
  logic                 load_ok;
  logic                 fit;
  logic                 cmp_fail;
  logic                 issue;
  logic                 rd_wrap;
  logic                 finish_go;
  logic                 cfg_wr;
  logic                 cfg_hit;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [SIZE_BITS-1:0] diff;

  assign n_act     = (CW'(block_count_r) > CW'(MAX_BLOCKS)) ? NB_W'(MAX_BLOCKS)
                                                            : NB_W'(block_count_r);
  assign start_idx = (NB_W'(ptr_r) >= n_act) ? '0 : ptr_r;
  assign in_acc    = in_valid && !in_stall;
  assign load_ok   = CW'(in_data.block_index) < CW'(MAX_BLOCKS);
  assign fit       = cmp_v_r && (req_r <= rdata_r);
  assign cmp_fail  = cmp_v_r && !fit && cmp_last_r;
  assign diff      = rdata_r - req_r;
  assign rd_wrap   = (NB_W'(rd_idx_r) + NB_W'(1)) == n_act;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[CFG_ADDR_W-1:2] == REG_BLOCK_COUNT;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(block_count_r) : '0;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == IW'(MAX_BLOCKS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.mode == MODE_ALLOC && n_act != '0) state_nxt = ST_SCAN;
          else state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (fit || cmp_fail) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    finish_go = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_r;
    mem_wdata = diff;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        mem_we    = in_acc && (in_data.mode == MODE_LOAD) && load_ok;
        mem_waddr = IW'(in_data.block_index);
        mem_wdata = in_data.size_kb;
      end
      ST_SCAN: begin
        issue  = (iss_cnt_r < n_act) && !fit;
        mem_we = fit;
      end
      ST_FINISH: begin
        finish_go = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_idx_r     <= '0;
      ptr_r         <= '0;
      block_count_r <= BLOCK_COUNT_RESET;
      cmp_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= issue;
      if (state_r == ST_CLEAR) clr_idx_r <= clr_idx_r + IW'(1);
      if (cfg_wr) block_count_r <= cfg_pwdata[CNT_BITS-1:0];
      if (state_r == ST_IDLE && in_acc && in_data.mode == MODE_LOAD && load_ok) begin
        ptr_r <= '0;
      end else if (state_r == ST_SCAN && fit) begin
        ptr_r <= cmp_idx_r;
      end
      if (finish_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) table_mem[mem_waddr] <= mem_wdata;
    rdata_r <= table_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= rd_idx_r;
    cmp_last_r <= iss_cnt_r == (n_act - NB_W'(1));
    if (state_r == ST_IDLE && in_acc) begin
      req_r     <= in_data.size_kb;
      rd_idx_r  <= start_idx;
      iss_cnt_r <= '0;
      if (in_data.mode == MODE_LOAD) begin
        res_r.allocated    <= load_ok;
        res_r.chosen_block <= in_data.block_index;
        res_r.size_before  <= load_ok ? in_data.size_kb : '0;
        res_r.fragment_kb  <= load_ok ? in_data.size_kb : '0;
      end else begin
        res_r <= '0;
      end
    end
    if (issue) begin
      rd_idx_r  <= rd_wrap ? '0 : rd_idx_r + IW'(1);
      iss_cnt_r <= iss_cnt_r + NB_W'(1);
    end
    if (state_r == ST_SCAN && fit) begin
      res_r.allocated    <= 1'b1;
      res_r.chosen_block <= IDX_BITS'(cmp_idx_r);
      res_r.size_before  <= rdata_r;
      res_r.fragment_kb  <= diff;
    end else if (state_r == ST_SCAN && cmp_fail) begin
      res_r <= '0;
    end
    if (finish_go) out_r <= res_r;
  end

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cmp_v_r) |-> (NB_W'(cmp_idx_r) < n_act))
    else $error("compared block lies outside the active blocks");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (iss_cnt_r <= n_act))
    else $error("scan read more blocks than are active");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    NB_W'(ptr_r) < NB_W'(MAX_BLOCKS))
    else $error("next-fit pointer outside the table");

  a_frag_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && res_r.allocated) |-> (res_r.fragment_kb <= res_r.size_before))
    else $error("fragment larger than the free size it came from");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !res_r.allocated)
      |-> (res_r.size_before == '0 && res_r.fragment_kb == '0))
    else $error("failed result carries sizes");

endmodule
